// ----- rtl/spectral_band_transient_shaper_assert.svh -----
// Assertion macros shared by the transient shaper modules.
// Needs signals named clk and rst_n in the module that expands them.
`ifndef SPECTRAL_BAND_TRANSIENT_SHAPER_ASSERT_SVH
`define SPECTRAL_BAND_TRANSIENT_SHAPER_ASSERT_SVH
`ifndef SYNTHESIS
`define SBTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbts assertion failed");
`define SBTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sbts assertion failed");
`else
`define SBTS_ASSERT(lbl, prop)
`define SBTS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/sbts_pkg.sv -----
// Shared widths, constants, types and the one-pole helper of the transient shaper.
// No dependencies.
package sbts_pkg;

  localparam int BAND_COUNT_DEF = 32;
  localparam int RAMP_STEPS_DEF = 8;

  localparam int BAND_W = 5;
  localparam int MAG_W  = 24;
  localparam int CRV_W  = 16;
  localparam int COEF_W = 16;
  localparam int SENS_W = 17;
  localparam int DB_W   = 6;
  localparam int ACT_W  = 17;
  localparam int GAIN_W = 20;
  localparam int STEP_W = 21;
  localparam int CD_W   = 4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [MAG_W-1:0]  MAG_MAX  = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 20'hFFFFF;
  localparam logic [GAIN_W-1:0] UNITY    = 20'h10000;
  localparam logic [29:0] LOG2_K  = 30'd713378626;
  localparam logic [15:0] EXP_C1  = 16'd45593;
  localparam logic [14:0] EXP_C2  = 15'd14824;
  localparam logic [12:0] EXP_C3  = 13'd5119;

  typedef enum logic [2:0] {
    REG_FAST  = 3'd0,
    REG_SLOW  = 3'd1,
    REG_REL   = 3'd2,
    REG_SENS  = 3'd3,
    REG_DB    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] fast_coeff;
    logic [COEF_W-1:0] slow_coeff;
    logic [COEF_W-1:0] release_coeff;
    logic [SENS_W-1:0] sensitivity;
    logic [DB_W-1:0]   range_db;
  } cfg_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic              inr;
    logic [MAG_W-1:0]  mag;
    logic [CRV_W-1:0]  atk;
    logic [CRV_W-1:0]  sus;
  } in_item_t;

  typedef struct packed {
    in_item_t          itm;
    logic [MAG_W-1:0]  fast;
    logic [MAG_W-1:0]  slow;
    logic [ACT_W-1:0]  rel;
    logic [GAIN_W-1:0] gcur;
    logic [GAIN_W-1:0] gtgt;
    logic [STEP_W-1:0] gstep;
    logic [CD_W-1:0]   rcd;
    logic [GAIN_W-1:0] tgt;
    logic [15:0]       f;
    logic [5:0]        n;
  } ctx_t;

  // y = (x*(1-c) + old*c) in Q0.16, rounded half up.
  function automatic logic [MAG_W-1:0] pole_fn(input logic [MAG_W-1:0] x,
                                               input logic [MAG_W-1:0] old,
                                               input logic [COEF_W-1:0] c);
    logic signed [MAG_W:0]          d;
    logic signed [MAG_W+COEF_W+1:0] pr;
    logic signed [MAG_W+COEF_W+2:0] s;
    d  = $signed({1'b0, old}) - $signed({1'b0, x});
    pr = d * $signed({1'b0, c});
    s  = $signed({3'b0, x, 16'b0}) + pr + 43'sd32768;
    return s[MAG_W+15:16];
  endfunction

endpackage

// ----- rtl/sbts_front.sv -----
// Input side of the transient shaper: accepts beats, checks the band range, queues items.
// Depends on sbts_pkg and the assertion macro header.
module sbts_front #(
  parameter int BAND_COUNT = sbts_pkg::BAND_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // band_index[4:0], band_magnitude[28:5], attack_curve[44:29], sustain_curve[60:45]
  input  logic [63:0]        in_tdata,
  output sbts_pkg::in_item_t q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  import sbts_pkg::*;
  `include "spectral_band_transient_shaper_assert.svh"

  in_item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  in_item_t              item;
  logic                  push;

  always_comb begin
    item.band = in_tdata[4:0];
    item.mag  = in_tdata[28:5];
    item.atk  = in_tdata[44:29];
    item.sus  = in_tdata[60:45];
    item.inr  = {2'b0, in_tdata[4:0]} < 7'(BAND_COUNT);
  end

  assign in_tready = cnt_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = cnt_r != '0;
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  `SBTS_ASSERT(a_cnt_max, cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `SBTS_ASSERT(a_pop_valid, q_pop |-> q_valid)
  `SBTS_ASSERT(a_cnt_up, (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1)

endmodule

// ----- rtl/sbts_back.sv -----
// Execution pipeline of the transient shaper: per-band state, envelopes, gain and ramp.
// Depends on sbts_pkg and the assertion macro header.
module sbts_back #(
  parameter int BAND_COUNT = sbts_pkg::BAND_COUNT_DEF,
  parameter int RAMP_STEPS = sbts_pkg::RAMP_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sbts_pkg::cfg_t              cfg,
  input  sbts_pkg::in_item_t          q_item,
  input  logic                        q_valid,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sbts_pkg::BAND_W-1:0] out_band,
  output logic [sbts_pkg::ACT_W-1:0]  out_activity,
  output logic [sbts_pkg::GAIN_W-1:0] out_gain
);
  import sbts_pkg::*;
  `include "spectral_band_transient_shaper_assert.svh"

  localparam int IDX_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int LAST  = 14;
  localparam int RSAFE = (RAMP_STEPS > 0) ? RAMP_STEPS : 1;
  localparam logic [24:0]       RECIP   = 25'((1 << 24) / RSAFE);
  localparam logic [STEP_W-1:0] RDIV    = STEP_W'(RSAFE);
  localparam logic [CD_W-1:0]   RAMP_CD = CD_W'(RAMP_STEPS);

  logic [MAG_W-1:0]  prev_r  [BAND_COUNT];
  logic [MAG_W-1:0]  fast_r  [BAND_COUNT];
  logic [MAG_W-1:0]  slow_r  [BAND_COUNT];
  logic [ACT_W-1:0]  rel_r   [BAND_COUNT];
  logic [GAIN_W-1:0] gcur_r  [BAND_COUNT];
  logic [GAIN_W-1:0] gtgt_r  [BAND_COUNT];
  logic [STEP_W-1:0] gstep_r [BAND_COUNT];
  logic [CD_W-1:0]   rcd_r   [BAND_COUNT];

  logic [LAST:1] v_r;
  ctx_t          c_r     [1:LAST];
  ctx_t          ctx_nxt [1:LAST];

  logic [MAG_W-1:0]  diff1_r, diff1_nxt;
  logic [40:0]       p2_r, p2_nxt;
  logic [MAG_W-1:0]  flux3_r, flux3_nxt;
  logic [ACT_W-1:0]  t5_r, t5_nxt;
  logic              sneg7_r, sneg7_nxt;
  logic [31:0]       smag7_r, smag7_nxt;
  logic              neg8_r;
  logic [22:0]       dbm8_r, dbm8_nxt;
  logic [21:0]       l9_r, l9_nxt;
  logic [12:0]       a10_r, a10_nxt;
  logic [14:0]       a11_r, a11_nxt;
  logic [15:0]       a12_r, a12_nxt;
  logic              chg14_r, chg14_nxt;
  logic              dneg14_r, dneg14_nxt;
  logic [STEP_W-1:0] dmag14_r, dmag14_nxt;
  logic [STEP_W-1:0] q14_r, q14_nxt;

  logic              out_v_r;
  logic [BAND_W-1:0] out_band_r;
  logic [ACT_W-1:0]  out_act_r;
  logic [GAIN_W-1:0] out_gain_r;

  logic              adv, issue, hz, wb_en, oor_out;
  logic [IDX_W-1:0]  idx_rd, idx_wb;
  logic [MAG_W-1:0]  fast_new, slow_new, rel_full;
  logic [GAIN_W-1:0] tgt_new;
  logic [GAIN_W-1:0] gcur_wb, gtgt_wb;
  logic [STEP_W-1:0] gstep_wb;
  logic [CD_W-1:0]   rcd_wb;

  assign adv    = !out_v_r || out_tready;
  assign idx_rd = IDX_W'(q_item.band);
  assign idx_wb = IDX_W'(c_r[LAST].itm.band);

  always_comb begin
    hz = 1'b0;
    for (int k = 1; k <= LAST; k++) begin
      if (v_r[k] && c_r[k].itm.inr && (c_r[k].itm.band == q_item.band)) begin
        hz = 1'b1;
      end
    end
  end

  assign issue   = adv && q_valid && !(q_item.inr && hz);
  assign q_pop   = issue;
  assign wb_en   = adv && v_r[LAST] && c_r[LAST].itm.inr;
  assign oor_out = adv && v_r[LAST] && !c_r[LAST].itm.inr;

  assign fast_new = pole_fn(flux3_r, c_r[3].fast, cfg.fast_coeff);
  assign slow_new = pole_fn(flux3_r, c_r[3].slow, cfg.slow_coeff);
  assign rel_full = pole_fn({7'b0, t5_r}, {7'b0, c_r[5].rel}, cfg.release_coeff);

  // Front of the pipeline: state read and magnitude increase; the context shifts on through the later stages.
  always_comb begin
    logic [MAG_W-1:0] prev;
    prev = prev_r[idx_rd];
    ctx_nxt[1]       = '0;
    ctx_nxt[1].itm   = q_item;
    ctx_nxt[1].fast  = fast_r[idx_rd];
    ctx_nxt[1].slow  = slow_r[idx_rd];
    ctx_nxt[1].rel   = rel_r[idx_rd];
    ctx_nxt[1].gcur  = gcur_r[idx_rd];
    ctx_nxt[1].gtgt  = gtgt_r[idx_rd];
    ctx_nxt[1].gstep = gstep_r[idx_rd];
    ctx_nxt[1].rcd   = rcd_r[idx_rd];
    diff1_nxt = (q_item.mag > prev) ? q_item.mag - prev : '0;
    for (int k = 2; k <= LAST; k++) begin
      ctx_nxt[k] = c_r[k-1];
    end
    ctx_nxt[4].fast = fast_new;
    ctx_nxt[4].slow = slow_new;
    ctx_nxt[6].rel  = rel_full[ACT_W-1:0];
    ctx_nxt[10].f   = l9_r[15:0];
    ctx_nxt[10].n   = l9_r[21:16];
    ctx_nxt[13].tgt = tgt_new;
  end

  // Flux, activity and the exponent.
  always_comb begin
    logic [44:0]              f10x;
    logic [MAG_W-1:0]         dfs;
    logic signed [CRV_W:0]    ds;
    logic signed [34:0]       prod;
    logic signed [35:0]       s_full;
    logic [37:0]              prdb;
    logic [52:0]              prl;
    logic [53:0]              rl;
    logic signed [21:0]       lsg;
    logic [28:0]              m10;
    logic [30:0]              m11;
    logic [31:0]              m12;
    p2_nxt = diff1_r * cfg.sensitivity;
    f10x = {1'b0, p2_r, 3'b0} + {3'b0, p2_r, 1'b0} + 45'd32768;
    flux3_nxt = (f10x[44:16] > {5'b0, MAG_MAX}) ? MAG_MAX : f10x[39:16];
    t5_nxt = '0;
    dfs = c_r[4].fast - c_r[4].slow;
    if (c_r[4].fast > c_r[4].slow) begin
      t5_nxt = (dfs >= 24'd32768) ? 17'h10000 : {dfs[15:0], 1'b0};
    end
    ds = $signed({c_r[6].itm.atk[15], c_r[6].itm.atk})
       - $signed({c_r[6].itm.sus[15], c_r[6].itm.sus});
    prod = ds * $signed({1'b0, c_r[6].rel});
    s_full = $signed({{4{c_r[6].itm.sus[15]}}, c_r[6].itm.sus, 16'b0}) + 36'(prod);
    sneg7_nxt = s_full[35];
    smag7_nxt = sneg7_nxt ? 32'(-s_full) : s_full[31:0];
    prdb = smag7_r * cfg.range_db;
    dbm8_nxt = 23'((prdb + 38'd16384) >> 15);
    prl = dbm8_r * LOG2_K;
    rl = {1'b0, prl} + 54'h80000000;
    lsg = $signed({1'b0, rl[52:32]});
    l9_nxt = neg8_r ? 22'(-lsg) : 22'(lsg);
    m10 = l9_r[15:0] * EXP_C3;
    a10_nxt = m10[28:16];
    m11 = c_r[10].f * (EXP_C2 + {2'b0, a10_r});
    a11_nxt = m11[30:16];
    m12 = c_r[11].f * (EXP_C1 + {1'b0, a11_r});
    a12_nxt = m12[31:16];
  end

  // Gain from the exponent: 2^n times the polynomial value, rounded, clamped to GAIN_MAX for n >= 4.
  always_comb begin
    logic [16:0]        p;
    logic signed [5:0]  n;
    logic [5:0]         m;
    logic [32:0]        pe;
    p = 17'h10000 + {1'b0, a12_r};
    n = $signed(c_r[12].n);
    m = 6'(-n);
    pe = '0;
    if (n >= 6'sd4) begin
      tgt_new = GAIN_MAX;
    end else if (n >= 6'sd0) begin
      tgt_new = {3'b0, p} << n[1:0];
    end else if (m >= 6'd32) begin
      tgt_new = '0;
    end else begin
      pe = {16'b0, p} + (33'd1 << (m - 6'd1));
      tgt_new = 20'(pe >> m);
    end
  end

  // Ramp step: divide by the ramp length through a reciprocal.
  always_comb begin
    logic signed [STEP_W-1:0] d;
    logic [45:0]              qp;
    d = $signed({1'b0, c_r[13].tgt}) - $signed({1'b0, c_r[13].gcur});
    chg14_nxt  = c_r[13].tgt != c_r[13].gtgt;
    dneg14_nxt = d[STEP_W-1];
    dmag14_nxt = dneg14_nxt ? STEP_W'(-d) : STEP_W'(d);
    qp = dmag14_nxt * RECIP;
    q14_nxt = qp[44:24];
  end

  // Writeback of ramp state.
  always_comb begin
    logic [STEP_W-1:0]        rem;
    logic [STEP_W-1:0]        q;
    logic signed [STEP_W:0]   g;
    rem      = dmag14_r - STEP_W'(q14_r * RDIV);
    q        = (rem >= RDIV) ? q14_r + 1'b1 : q14_r;
    gcur_wb  = c_r[LAST].gcur;
    gtgt_wb  = c_r[LAST].gtgt;
    gstep_wb = c_r[LAST].gstep;
    rcd_wb   = c_r[LAST].rcd;
    g        = '0;
    if (chg14_r) begin
      if (RAMP_STEPS == 0) begin
        gcur_wb = c_r[LAST].tgt;
        gtgt_wb = c_r[LAST].tgt;
        rcd_wb  = '0;
      end else begin
        gtgt_wb  = c_r[LAST].tgt;
        rcd_wb   = RAMP_CD;
        gstep_wb = dneg14_r ? STEP_W'(-q) : q;
      end
    end
    if (rcd_wb != '0) begin
      rcd_wb = rcd_wb - 1'b1;
      if (rcd_wb != '0) begin
        g = $signed({2'b0, gcur_wb}) + $signed({gstep_wb[STEP_W-1], gstep_wb});
        if (g < 0) begin
          gcur_wb = '0;
        end else if (g > $signed({2'b0, GAIN_MAX})) begin
          gcur_wb = GAIN_MAX;
        end else begin
          gcur_wb = g[GAIN_W-1:0];
        end
      end else begin
        gcur_wb = gtgt_wb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[LAST-1:1], issue};
      out_v_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= LAST; k++) begin
        c_r[k] <= ctx_nxt[k];
      end
      diff1_r  <= diff1_nxt;
      p2_r     <= p2_nxt;
      flux3_r  <= flux3_nxt;
      t5_r     <= t5_nxt;
      sneg7_r  <= sneg7_nxt;
      smag7_r  <= smag7_nxt;
      neg8_r   <= sneg7_r;
      dbm8_r   <= dbm8_nxt;
      l9_r     <= l9_nxt;
      a10_r    <= a10_nxt;
      a11_r    <= a11_nxt;
      a12_r    <= a12_nxt;
      chg14_r  <= chg14_nxt;
      dneg14_r <= dneg14_nxt;
      dmag14_r <= dmag14_nxt;
      q14_r    <= q14_nxt;
      if (v_r[LAST]) begin
        out_band_r <= c_r[LAST].itm.band;
        out_act_r  <= c_r[LAST].itm.inr ? c_r[LAST].rel : '0;
        out_gain_r <= c_r[LAST].itm.inr ? gcur_wb : UNITY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BAND_COUNT; i++) begin
        prev_r[i]  <= '0;
        fast_r[i]  <= '0;
        slow_r[i]  <= '0;
        rel_r[i]   <= '0;
        gcur_r[i]  <= UNITY;
        gtgt_r[i]  <= UNITY;
        gstep_r[i] <= '0;
        rcd_r[i]   <= '0;
      end
    end else if (wb_en) begin
      prev_r[idx_wb]  <= c_r[LAST].itm.mag;
      fast_r[idx_wb]  <= c_r[LAST].fast;
      slow_r[idx_wb]  <= c_r[LAST].slow;
      rel_r[idx_wb]   <= c_r[LAST].rel;
      gcur_r[idx_wb]  <= gcur_wb;
      gtgt_r[idx_wb]  <= gtgt_wb;
      gstep_r[idx_wb] <= gstep_wb;
      rcd_r[idx_wb]   <= rcd_wb;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_band     = out_band_r;
  assign out_activity = out_act_r;
  assign out_gain     = out_gain_r;

  `SBTS_ASSERT(a_oor_unity, oor_out |=> (out_gain_r == UNITY && out_act_r == '0))
  `SBTS_ASSERT(a_cd_bound, wb_en |-> rcd_wb <= RAMP_CD)
  `SBTS_ASSERT(a_gain_hold, (wb_en && !chg14_r && c_r[LAST].rcd == '0) |-> gcur_wb == c_r[LAST].gcur)

endmodule

// ----- rtl/spectral_band_transient_shaper.sv -----
// Top level of the spectral band transient shaper: configuration registers and the
// front and back parts. Depends on sbts_pkg, sbts_front and sbts_back.
//
// Every accepted band beat yields one result beat, in order. Beats pass a four-beat
// input queue into a 14-stage execution pipeline and then an output register. A beat
// waits in the queue while any of the up to 14 earlier beats still in the pipeline
// addresses the same band, until that beat has written back its band state, so a run
// of beats on a single band enters the pipeline only once the previous beat has left
// it, while beats that cycle through more than 14 bands flow at one per clock while the
// output accepts. A stalled output holds the whole pipeline. Per-band state sits in
// flip-flops that reset clears at once; there is no clearing pass. Registers should be
// written only while no beat is in flight.
module spectral_band_transient_shaper #(
  parameter int BAND_COUNT = sbts_pkg::BAND_COUNT_DEF,
  parameter int RAMP_STEPS = sbts_pkg::RAMP_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // band_index[4:0], band_magnitude[28:5], attack_curve[44:29], sustain_curve[60:45]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_band[4:0], activity[21:5], band_gain[41:22]
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sbts_pkg::*;

  cfg_t              cfg_r;
  in_item_t          q_item;
  logic              q_valid, q_pop, wr_en;
  reg_idx_t          ridx;
  logic [BAND_W-1:0] o_band;
  logic [ACT_W-1:0]  o_act;
  logic [GAIN_W-1:0] o_gain;

  assign cfg_pready = 1'b1;
  assign ridx       = reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_coeff    <= '0;
      cfg_r.slow_coeff    <= '0;
      cfg_r.release_coeff <= '0;
      cfg_r.sensitivity   <= 17'd32768;
      cfg_r.range_db      <= 6'd18;
    end else if (wr_en) begin
      unique case (ridx)
        REG_FAST: cfg_r.fast_coeff    <= cfg_pwdata[COEF_W-1:0];
        REG_SLOW: cfg_r.slow_coeff    <= cfg_pwdata[COEF_W-1:0];
        REG_REL:  cfg_r.release_coeff <= cfg_pwdata[COEF_W-1:0];
        REG_SENS: cfg_r.sensitivity   <= cfg_pwdata[SENS_W-1:0];
        REG_DB:   cfg_r.range_db      <= cfg_pwdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_FAST: cfg_prdata = {16'b0, cfg_r.fast_coeff};
      REG_SLOW: cfg_prdata = {16'b0, cfg_r.slow_coeff};
      REG_REL:  cfg_prdata = {16'b0, cfg_r.release_coeff};
      REG_SENS: cfg_prdata = {15'b0, cfg_r.sensitivity};
      REG_DB:   cfg_prdata = {26'b0, cfg_r.range_db};
      default:  cfg_prdata = '0;
    endcase
  end

  sbts_front #(
    .BAND_COUNT(BAND_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  sbts_back #(
    .BAND_COUNT(BAND_COUNT),
    .RAMP_STEPS(RAMP_STEPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_band    (o_band),
    .out_activity(o_act),
    .out_gain    (o_gain)
  );

  assign out_tdata = {6'b0, o_gain, o_act, o_band};

endmodule

// ----- tb/spectral_band_transient_shaper_tb.sv -----
// Self-checking testbench for spectral_band_transient_shaper: streams band items,
// predicts each band's activity and smoothed gain, and checks every result beat.
// Depends on sbts_pkg and the RTL of the block; needs no files or arguments.
module spectral_band_transient_shaper_tb;
  import sbts_pkg::*;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [ACT_W-1:0]  act;
    logic [GAIN_W-1:0] gain;
  } band_result_t;

  localparam int N_BANDS    = BAND_COUNT_DEF;
  localparam int N_RAMP     = RAMP_STEPS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  spectral_band_transient_shaper u_top (.*);

  always #2 clk = ~clk;

  // Shadow configuration and per-band state.
  logic [15:0] m_fast, m_slow, m_rel;
  logic [16:0] m_sens;
  logic [5:0]  m_db;
  logic [23:0] prev_mag [N_BANDS];
  logic [23:0] env_fast [N_BANDS];
  logic [23:0] env_slow [N_BANDS];
  logic [16:0] activity_st [N_BANDS];
  logic [19:0] gain_cur [N_BANDS];
  logic [19:0] gain_tgt [N_BANDS];
  int          gain_inc [N_BANDS];
  int          ramp_left [N_BANDS];

  band_result_t pending_results[$];
  int  tx_idle = 0, rx_idle = 0, rx_hold = 0;
  int  mismatches = 0, beats_in = 0, beats_out = 0, idle_cycles = 0;
  bit  timed_out = 0;

  function automatic longint pole_blend(longint x, longint prev_y, longint c);
    return (x * (65536 - c) + prev_y * c + 32768) >>> 16;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint target_gain(longint atk, longint sus, longint t, longint db);
    longint s, dbq, l, lb, f, a, p;
    int n;
    s   = atk * t + sus * (65536 - t);
    dbq = round_shift(s * db, 15);
    l   = round_shift(dbq * 713378626, 32);
    lb  = l + (longint'(64) << 16);
    n   = int'(lb >>> 16) - 64;
    f   = lb & 16'hFFFF;
    a   = (f * 5119) >>> 16;
    a   = (f * (14824 + a)) >>> 16;
    a   = (f * (45593 + a)) >>> 16;
    p   = 65536 + a;
    if (n >= 4) return 1048575;
    if (n >= 0) begin
      p = p << n;
      return p > 1048575 ? 1048575 : p;
    end
    if (-n >= 32) return 0;
    p = (p + (longint'(1) << (-n - 1))) >>> (-n);
    return p > 1048575 ? 1048575 : p;
  endfunction

  function automatic band_result_t shape_band(int b, longint mag, longint atk, longint sus);
    band_result_t r;
    longint flux, t, d, tg, g;
    r.band = BAND_W'(b);
    if (b >= N_BANDS) begin
      r.act = '0;
      r.gain = UNITY;
      return r;
    end
    flux = mag > prev_mag[b] ? mag - prev_mag[b] : 0;
    prev_mag[b] = MAG_W'(mag);
    flux = (flux * m_sens * 10 + 32768) >>> 16;
    if (flux > 24'hFFFFFF) flux = 24'hFFFFFF;
    env_fast[b] = MAG_W'(pole_blend(flux, env_fast[b], m_fast));
    env_slow[b] = MAG_W'(pole_blend(flux, env_slow[b], m_slow));
    t = 0;
    if (env_fast[b] > env_slow[b]) begin
      d = env_fast[b] - env_slow[b];
      t = d >= 32768 ? 65536 : 2 * d;
    end
    activity_st[b] = ACT_W'(pole_blend(t, activity_st[b], m_rel));
    tg = target_gain(atk, sus, activity_st[b], m_db);
    if (tg != gain_tgt[b]) begin
      if (N_RAMP <= 0) begin
        gain_cur[b] = GAIN_W'(tg);
        gain_tgt[b] = GAIN_W'(tg);
        ramp_left[b] = 0;
      end else begin
        gain_tgt[b] = GAIN_W'(tg);
        ramp_left[b] = N_RAMP & 15;
        gain_inc[b] = (int'(tg) - int'(gain_cur[b])) / N_RAMP;
      end
    end
    if (ramp_left[b] > 0) begin
      ramp_left[b]--;
      if (ramp_left[b] > 0) begin
        g = longint'(gain_cur[b]) + gain_inc[b];
        if (g < 0) g = 0;
        if (g > 1048575) g = 1048575;
        gain_cur[b] = GAIN_W'(g);
      end else begin
        gain_cur[b] = gain_tgt[b];
      end
    end
    r.act = activity_st[b];
    r.gain = gain_cur[b];
    return r;
  endfunction

  task automatic send_band(input int b, input logic [23:0] mag, input logic [15:0] atk,
                           input logic [15:0] sus);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b0, sus, atk, mag, b[4:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(shape_band(b, mag, $signed(atk), $signed(sus)));
    beats_in++;
  endtask

  task automatic finish_send();
    in_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_FAST: m_fast = val[15:0];
      REG_SLOW: m_slow = val[15:0];
      REG_REL:  m_rel  = val[15:0];
      REG_SENS: m_sens = val[16:0];
      REG_DB:   m_db   = val[5:0];
      default: ;
    endcase
  endtask

  task automatic wait_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] f, input logic [31:0] s, input logic [31:0] r,
                             input logic [31:0] sens, input logic [31:0] db);
    wait_results();
    write_reg(REG_FAST, f);
    write_reg(REG_SLOW, s);
    write_reg(REG_REL, r);
    write_reg(REG_SENS, sens);
    write_reg(REG_DB, db);
  endtask

  // Rising and falling magnitudes, mostly on bands 0 to 3, so the envelopes see transients.
  task automatic random_burst(input int count);
    int b;
    logic [23:0] mag;
    for (int i = 0; i < count; i++) begin
      b = $urandom_range(9) < 7 ? $urandom_range(3) : $urandom_range(31);
      case ($urandom_range(9))
        0:       mag = MAG_W'($urandom);
        1:       mag = 24'hFFFFFF;
        2:       mag = 0;
        3, 4, 5: mag = MAG_W'(prev_mag[b] + $urandom_range(40000));
        default: mag = prev_mag[b] > 3000 ? MAG_W'(prev_mag[b] - $urandom_range(3000)) : '0;
      endcase
      send_band(b, mag, 16'($urandom), $urandom_range(9) == 0 ? 16'h8000 : 16'($urandom));
    end
    finish_send();
  endtask

  task automatic test_directed();
    send_band(0, 0, 16'h7FFF, 16'h8001);
    send_band(31, 24'hFFFFFF, 16'h7FFF, 16'h8001);
    send_band(31, 24'hFFFFFF, 16'h8000, 16'h8000);
    send_band(0, 24'h010000, 16'h7FFF, 16'h8000);
    send_band(1, 24'h800000, 16'h0000, 16'h7FFF);
    send_band(0, 24'h020000, 16'h8001, 16'h0000);
    send_band(0, 24'h000001, 16'h7FFF, 16'h7FFF);
    for (int i = 0; i < 10; i++) send_band(2, 24'(i * 30000), 16'h7FFF, 16'h8000);
    send_band(2, 0, 16'h8000, 16'h7FFF);
    send_band(17, 24'h5A5A5A, 16'hA5A5, 16'h5A5A);
    finish_send();
  endtask

  task automatic test_register_extremes();
    load_config(32'hFFFF_0000, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0001_0000, 48);
    write_reg(5, 32'hFFFF_FFFF);
    write_reg(6, 32'h0);
    write_reg(7, 32'h1234_5678);
    random_burst(60);
    load_config(0, 0, 0, 32'h0001_FFFF, 63);
    random_burst(60);
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
    random_burst(30);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = ph == 0 ? 8 : (ph == 1 ? 60 : 0);
      rx_idle = ph == 0 ? 60 : (ph == 1 ? 8 : 0);
      load_config($urandom_range(65535), 32'hF000 | $urandom, $urandom,
                  $urandom_range(65536), $urandom_range(48));
      random_burst(130);
    end
  endtask

  task automatic test_backpressure();
    tx_idle = 0;
    rx_idle = 0;
    rx_hold = 300;
    random_burst(60);
    wait_results();
    random_burst(20);
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_tready <= $urandom_range(99) >= rx_idle;
    end
  end

  always @(posedge clk) begin
    band_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[4:0], out_tdata[21:5], out_tdata[41:22]};
      beats_out++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h.", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: band %0d/%0d activity %0d/%0d gain %0d/%0d (exp/act).",
                     want.band, got.band, want.act, got.act, want.gain, got.gain);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("spectral_band_transient_shaper verification failed");
      $finish;
    end
  end

  initial begin
    m_fast = 0; m_slow = 0; m_rel = 0; m_sens = 32768; m_db = 18;
    for (int i = 0; i < N_BANDS; i++) begin
      prev_mag[i] = 0; env_fast[i] = 0; env_slow[i] = 0; activity_st[i] = 0;
      gain_cur[i] = UNITY; gain_tgt[i] = UNITY; gain_inc[i] = 0; ramp_left[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    wait_results();
    $display("Sent %0d band beats and checked %0d results over register extremes,", beats_in,
             beats_out);
    $display("random settings, both idle patterns and a long output stall.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("spectral_band_transient_shaper verification clean");
    end else begin
      $display("spectral_band_transient_shaper verification failed");
    end
    $finish;
  end
endmodule
